// ===== rtl/rrqs_pkg.sv =====
// Shared types and codes for the round-robin quantum scheduler.
package rrqs_pkg;

  localparam int unsigned IdW    = 10;
  localparam int unsigned LenW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  localparam logic [LenW-1:0] QuantumReset = 16'd4;

  localparam logic MODE_SUBMIT   = 1'b0;
  localparam logic MODE_SCHEDULE = 1'b1;

  localparam logic POLICY_RR   = 1'b0;
  localparam logic POLICY_FCFS = 1'b1;

  localparam logic REG_QUANTUM = 1'b0;
  localparam logic REG_POLICY  = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]  job_id;
    logic [LenW-1:0] remaining;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic push;
  } ctrl_t;

endpackage

// ===== rtl/rrqs_cell.sv =====
// One queue cell: holds a job entry, shifts toward the head, loads at the tail.
module rrqs_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rrqs_pkg::ctrl_t  ctrl_i,
  input  logic             prev_valid_i,
  input  logic             next_valid_i,
  input  rrqs_pkg::entry_t next_entry_i,
  input  rrqs_pkg::entry_t push_entry_i,
  output logic             valid_o,
  output rrqs_pkg::entry_t entry_o
);

  logic             valid_q, valid_d;
  rrqs_pkg::entry_t entry_q, entry_d;
  logic             load_push;

  always_comb begin
    load_push = ctrl_i.push &&
                (ctrl_i.shift ? (valid_q && !next_valid_i) : (!valid_q && prev_valid_i));
    valid_d   = valid_q;
    entry_d   = entry_q;
    if (load_push) begin
      valid_d = 1'b1;
      entry_d = push_entry_i;
    end else if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

// ===== rtl/rrqs_chain.sv =====
// Row of queue cells forming the job FIFO, head at cell zero.
module rrqs_chain #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rrqs_pkg::ctrl_t  ctrl_i,
  input  rrqs_pkg::entry_t push_entry_i,
  output logic             head_valid_o,
  output rrqs_pkg::entry_t head_entry_o,
  output logic             full_o
);

  logic             valid [QUEUE_DEPTH];
  rrqs_pkg::entry_t entry [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             prev_valid;
    logic             next_valid;
    rrqs_pkg::entry_t next_entry;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = valid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_entry = entry[i];
    end else begin : g_inner
      assign next_valid = valid[i+1];
      assign next_entry = entry[i+1];
    end

    rrqs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_entry_i (next_entry),
      .push_entry_i (push_entry_i),
      .valid_o      (valid[i]),
      .entry_o      (entry[i])
    );
  end

  assign head_valid_o = valid[0];
  assign head_entry_o = entry[0];
  assign full_o       = valid[QUEUE_DEPTH-1];

  for (genvar k = 0; k + 1 < QUEUE_DEPTH; k++) begin : g_chk
    a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid[k+1] |-> valid[k])
      else $error("queue occupancy has a gap");
  end

endmodule

// ===== rtl/round_robin_quantum_scheduler.sv =====
// Top level of the round-robin quantum scheduler.
//
// Input channel (in_valid_i / in_stall_o) carries one transaction per item:
// mode_i selects submit or schedule step, job_id_i and job_length_i describe
// the submitted job. Output channel (out_valid_o / out_stall_i) returns one
// transaction per item with the accept/reject flags, the dispatched slice and
// the scheduler time after the item.
// Each item is decided in the cycle it is accepted; its result is registered
// in the output register. A new item is taken every cycle while the output
// register is free or being drained, so throughput is one item per cycle.
// The job queue is a row of QUEUE_DEPTH cells that shift toward the head on a
// dispatch and load the tail on a submit or requeue; the head cell is read
// directly, so no memory port bounds the rate. While the receiver stalls with
// a result pending, in_stall_o is raised and the pending result holds. Reset
// empties the queue, clears the time and work counters and sets quantum to 4
// and policy to round robin. Configuration (quantum at 0x0, policy at 0x4) is
// written over the APB port by the user while idle; the block does not check.
module round_robin_quantum_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrqs_pkg::AddrW-1:0]    paddr,
  input  logic [rrqs_pkg::DataW-1:0]    pwdata,
  output logic [rrqs_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [rrqs_pkg::IdW-1:0]      job_id_i,
  input  logic [rrqs_pkg::LenW-1:0]     job_length_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic                          rejected_full_o,
  output logic                          issued_o,
  output logic [rrqs_pkg::IdW-1:0]      issued_job_id_o,
  output logic [rrqs_pkg::LenW-1:0]     slice_length_o,
  output logic                          job_finished_o,
  output logic [rrqs_pkg::TimeW-1:0]    now_time_o
);

  logic [rrqs_pkg::LenW-1:0]  quantum_q;
  logic                       policy_q;
  logic [rrqs_pkg::TimeW-1:0] current_time_q, current_time_d;
  logic [rrqs_pkg::TimeW-1:0] total_work_q, total_work_d;
  logic                       out_valid_q;
  logic                       accepted_q, rejected_q, issued_q, finished_q;
  logic [rrqs_pkg::IdW-1:0]   issued_id_q;
  logic [rrqs_pkg::LenW-1:0]  slice_q;

  logic                       cfg_write;
  logic                       accept;
  logic                       head_valid;
  rrqs_pkg::entry_t           head_entry;
  logic                       full;
  rrqs_pkg::ctrl_t            ctrl;
  rrqs_pkg::entry_t           push_entry;
  logic [rrqs_pkg::LenW-1:0]  q_eff, rr_slice, slice, left;
  logic                       is_submit, submit_ok, submit_full, sched_ok;
  logic [rrqs_pkg::TimeW:0]   time_sum, work_sum;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      rrqs_pkg::REG_QUANTUM: prdata = {{(rrqs_pkg::DataW-rrqs_pkg::LenW){1'b0}}, quantum_q};
      rrqs_pkg::REG_POLICY:  prdata = {{(rrqs_pkg::DataW-1){1'b0}}, policy_q};
      default:               prdata = '0;
    endcase
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign q_eff    = (quantum_q == '0) ? rrqs_pkg::LenW'(1) : quantum_q;
  assign rr_slice = (head_entry.remaining < q_eff) ? head_entry.remaining : q_eff;
  assign slice    = (policy_q == rrqs_pkg::POLICY_FCFS) ? head_entry.remaining : rr_slice;
  assign left     = head_entry.remaining - slice;

  assign is_submit   = (mode_i == rrqs_pkg::MODE_SUBMIT);
  assign submit_ok   = is_submit && (job_length_i != '0) && !full;
  assign submit_full = is_submit && (job_length_i != '0) && full;
  assign sched_ok    = !is_submit && head_valid && (total_work_q >= current_time_q);

  assign ctrl.shift = accept && sched_ok;
  assign ctrl.push  = accept && (submit_ok || (sched_ok && (left != '0)));

  always_comb begin
    if (sched_ok) begin
      push_entry.job_id    = head_entry.job_id;
      push_entry.remaining = left;
    end else begin
      push_entry.job_id    = job_id_i;
      push_entry.remaining = job_length_i;
    end
  end

  assign time_sum = {1'b0, current_time_q} + {{(rrqs_pkg::TimeW-rrqs_pkg::LenW+1){1'b0}}, slice};
  assign work_sum = {1'b0, total_work_q} +
                    {{(rrqs_pkg::TimeW-rrqs_pkg::LenW+1){1'b0}}, job_length_i};

  always_comb begin
    current_time_d = current_time_q;
    total_work_d   = total_work_q;
    if (accept && sched_ok) begin
      current_time_d = time_sum[rrqs_pkg::TimeW] ? '1 : time_sum[rrqs_pkg::TimeW-1:0];
    end
    if (accept && submit_ok) begin
      total_work_d = work_sum[rrqs_pkg::TimeW] ? '1 : work_sum[rrqs_pkg::TimeW-1:0];
    end
  end

  rrqs_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .push_entry_i (push_entry),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry),
    .full_o       (full)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q      <= rrqs_pkg::QuantumReset;
      policy_q       <= rrqs_pkg::POLICY_RR;
      current_time_q <= '0;
      total_work_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_write && (paddr[2] == rrqs_pkg::REG_QUANTUM)) begin
        quantum_q <= pwdata[rrqs_pkg::LenW-1:0];
      end
      if (cfg_write && (paddr[2] == rrqs_pkg::REG_POLICY)) begin
        policy_q <= pwdata[0];
      end
      current_time_q <= current_time_d;
      total_work_q   <= total_work_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      accepted_q  <= submit_ok;
      rejected_q  <= submit_full;
      issued_q    <= sched_ok;
      issued_id_q <= sched_ok ? head_entry.job_id : '0;
      slice_q     <= sched_ok ? slice : '0;
      finished_q  <= sched_ok && (left == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = accepted_q;
  assign rejected_full_o = rejected_q;
  assign issued_o        = issued_q;
  assign issued_job_id_o = issued_id_q;
  assign slice_length_o  = slice_q;
  assign job_finished_o  = finished_q;
  assign now_time_o      = current_time_q;

  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $countones({accepted_q, rejected_q, issued_q}) <= 1)
    else $error("more than one outcome flagged");

  a_finish_needs_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && finished_q) |-> issued_q)
    else $error("finished without a dispatched slice");

  a_slice_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && issued_q) |-> (slice_q != '0))
    else $error("dispatched an empty slice");

  a_time_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (current_time_q >= $past(current_time_q)))
    else $error("scheduler time went backward");

endmodule

// ===== tb/round_robin_quantum_scheduler_test.sv =====
// Testbench for the round-robin quantum scheduler: random traffic, live prediction, field checks.
module round_robin_quantum_scheduler_test;

  localparam int unsigned IdW   = rrqs_pkg::IdW;
  localparam int unsigned LenW  = rrqs_pkg::LenW;
  localparam int unsigned TimeW = rrqs_pkg::TimeW;
  localparam int unsigned DataW = rrqs_pkg::DataW;
  localparam int unsigned AddrW = rrqs_pkg::AddrW;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned PhaseItems = 205;

  typedef struct packed {
    logic            mode;
    logic [IdW-1:0]  job_id;
    logic [LenW-1:0] job_length;
  } job_request_t;

  typedef struct packed {
    logic             accepted;
    logic             rejected_full;
    logic             issued;
    logic [IdW-1:0]   issued_job_id;
    logic [LenW-1:0]  slice_length;
    logic             job_finished;
    logic [TimeW-1:0] now_time;
  } dispatch_outcome_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             mode_i;
  logic [IdW-1:0]   job_id_i;
  logic [LenW-1:0]  job_length_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             accepted_o;
  logic             rejected_full_o;
  logic             issued_o;
  logic [IdW-1:0]   issued_job_id_o;
  logic [LenW-1:0]  slice_length_o;
  logic             job_finished_o;
  logic [TimeW-1:0] now_time_o;

  round_robin_quantum_scheduler #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .job_id_i,
    .job_length_i,
    .out_valid_o,
    .out_stall_i,
    .accepted_o,
    .rejected_full_o,
    .issued_o,
    .issued_job_id_o,
    .slice_length_o,
    .job_finished_o,
    .now_time_o
  );

  job_request_t      job_requests[$];
  dispatch_outcome_t pending_outcomes[$];

  logic [IdW-1:0]   slot_id   [QueueDepth];
  logic [LenW-1:0]  slot_len  [QueueDepth];
  logic [LenW-1:0]  slot_used [QueueDepth];
  int unsigned      head_slot;
  int unsigned      tail_slot;
  int unsigned      queued_jobs;
  logic [TimeW-1:0] clock_now;
  logic [TimeW-1:0] work_sum;
  logic [LenW-1:0]  cfg_quantum;
  logic             cfg_policy;

  int unsigned error_count;
  int unsigned quiet_cycles;
  int unsigned in_gap;
  int unsigned out_gap;
  bit          in_fire;
  bit          idle_on;

  always #5 clk_i = ~clk_i;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TimeW] ? '1 : sum[TimeW-1:0];
  endfunction

  function automatic void enqueue_job(input logic [IdW-1:0] id, input logic [LenW-1:0] len,
                                      input logic [LenW-1:0] used);
    slot_id[tail_slot]   = id;
    slot_len[tail_slot]  = len;
    slot_used[tail_slot] = used;
    tail_slot = (tail_slot + 1) % QueueDepth;
    queued_jobs++;
  endfunction

  function automatic dispatch_outcome_t schedule_outcome(input job_request_t req);
    dispatch_outcome_t res;
    logic [IdW-1:0]    jid;
    logic [LenW-1:0]   jlen;
    logic [LenW-1:0]   used;
    logic [LenW-1:0]   remaining;
    logic [LenW-1:0]   eff_quantum;
    logic [LenW-1:0]   slice;
    res = '0;
    if (req.mode == rrqs_pkg::MODE_SUBMIT) begin
      if (req.job_length != '0) begin
        if (queued_jobs >= QueueDepth) begin
          res.rejected_full = 1'b1;
        end else begin
          enqueue_job(req.job_id, req.job_length, '0);
          work_sum = sat_add(work_sum, TimeW'(req.job_length));
          res.accepted = 1'b1;
        end
      end
    end else if (work_sum >= clock_now && queued_jobs > 0) begin
      jid  = slot_id[head_slot];
      jlen = slot_len[head_slot];
      used = slot_used[head_slot];
      remaining = (jlen > used) ? jlen - used : '0;
      eff_quantum = (cfg_quantum == '0) ? LenW'(1) : cfg_quantum;
      head_slot = (head_slot + 1) % QueueDepth;
      queued_jobs--;
      if (cfg_policy == rrqs_pkg::POLICY_FCFS) begin
        slice = remaining;
      end else begin
        slice = (remaining < eff_quantum) ? remaining : eff_quantum;
      end
      used = used + slice;
      clock_now = sat_add(clock_now, TimeW'(slice));
      res.issued        = 1'b1;
      res.issued_job_id = jid;
      res.slice_length  = slice;
      if (used < jlen) begin
        enqueue_job(jid, jlen, used);
      end else begin
        res.job_finished = 1'b1;
      end
    end
    res.now_time = clock_now;
    return res;
  endfunction

  function automatic job_request_t random_request(input int unsigned submit_pct);
    job_request_t req;
    req.mode   = ($urandom_range(0, 99) < submit_pct) ? rrqs_pkg::MODE_SUBMIT
                                                      : rrqs_pkg::MODE_SCHEDULE;
    req.job_id = IdW'($urandom_range(0, 1023));
    case ($urandom_range(0, 15))
      0: begin
        req.job_length = '0;
      end
      1: begin
        req.job_length = '1;
      end
      2, 3: begin
        req.job_length = LenW'($urandom_range(0, 65535));
      end
      default: begin
        req.job_length = LenW'($urandom_range(1, 40));
      end
    endcase
    return req;
  endfunction

  task automatic add_request(input logic mode, input logic [IdW-1:0] id,
                             input logic [LenW-1:0] len);
    job_request_t req;
    req.mode       = mode;
    req.job_id     = id;
    req.job_length = len;
    job_requests.push_back(req);
  endtask

  task automatic check_field(input string name, input logic [TimeW-1:0] expv,
                             input logic [TimeW-1:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      error_count++;
    end
  endtask

  task automatic wait_drained();
    while (job_requests.size() != 0 || in_valid_i || pending_outcomes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic regsel, input logic [DataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regsel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    quiet_cycles = 0;
    if (regsel == rrqs_pkg::REG_QUANTUM) begin
      cfg_quantum = value[LenW-1:0];
    end else begin
      cfg_policy = value[0];
    end
    @(negedge clk_i);
    if (regsel == rrqs_pkg::REG_QUANTUM) begin
      check_field("prdata", TimeW'(value[LenW-1:0]), prdata);
    end else begin
      check_field("prdata", TimeW'(value[0]), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drive the input channel: hold a stalled transaction, otherwise idle or advance.
  always @(negedge clk_i) begin : drive_requests
    job_request_t req;
    if (rst_ni) begin
      if (in_fire && idle_on && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(1, 12);
      end
      if (in_valid_i && !in_fire) begin
        in_valid_i <= 1'b1;
      end else if (in_gap != 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (job_requests.size() != 0) begin
        req = job_requests.pop_front();
        in_valid_i   <= 1'b1;
        mode_i       <= req.mode;
        job_id_i     <= req.job_id;
        job_length_i <= req.job_length;
      end else begin
        in_valid_i <= 1'b0;
      end
      in_fire = 1'b0;
    end
  end

  always @(negedge clk_i) begin : drive_stall
    if (rst_ni) begin
      if (out_gap != 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (idle_on && $urandom_range(0, 7) == 0) begin
          out_gap = $urandom_range(1, 12);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watch_channels
    dispatch_outcome_t want;
    if (rst_ni) begin
      quiet_cycles++;
      if (out_valid_o && !out_stall_i) begin
        quiet_cycles = 0;
        if (pending_outcomes.size() == 0) begin
          $error("result transaction with no outstanding request");
          error_count++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("accepted", TimeW'(want.accepted), TimeW'(accepted_o));
          check_field("rejected_full", TimeW'(want.rejected_full), TimeW'(rejected_full_o));
          check_field("issued", TimeW'(want.issued), TimeW'(issued_o));
          check_field("issued_job_id", TimeW'(want.issued_job_id), TimeW'(issued_job_id_o));
          check_field("slice_length", TimeW'(want.slice_length), TimeW'(slice_length_o));
          check_field("job_finished", TimeW'(want.job_finished), TimeW'(job_finished_o));
          check_field("now_time", want.now_time, now_time_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        quiet_cycles = 0;
        pending_outcomes.push_back(schedule_outcome({mode_i, job_id_i, job_length_i}));
        in_fire = 1'b1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [LenW-1:0] q_pick;
    logic            p_pick;
    int unsigned     pct;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    mode_i       = rrqs_pkg::MODE_SUBMIT;
    job_id_i     = '0;
    job_length_i = '0;
    out_stall_i  = 1'b0;
    head_slot    = 0;
    tail_slot    = 0;
    queued_jobs  = 0;
    clock_now    = '0;
    work_sum     = '0;
    cfg_quantum  = rrqs_pkg::QuantumReset;
    cfg_policy   = rrqs_pkg::POLICY_RR;
    error_count  = 0;
    quiet_cycles = 0;
    in_gap       = 0;
    out_gap      = 0;
    in_fire      = 1'b0;
    idle_on      = 1'b1;
    for (int i = 0; i < QueueDepth; i++) begin
      slot_id[i]   = '0;
      slot_len[i]  = '0;
      slot_used[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_request(rrqs_pkg::MODE_SCHEDULE, 10'd1023, 16'hFFFF);
    add_request(rrqs_pkg::MODE_SUBMIT, 10'd0, 16'd0);
    add_request(rrqs_pkg::MODE_SUBMIT, 10'd1023, 16'hFFFF);
    add_request(rrqs_pkg::MODE_SUBMIT, 10'd0, 16'd1);
    add_request(rrqs_pkg::MODE_SUBMIT, 10'h155, 16'h5555);
    add_request(rrqs_pkg::MODE_SUBMIT, 10'h2AA, 16'hAAAA);
    for (int i = 0; i < 12; i++) begin
      add_request(rrqs_pkg::MODE_SUBMIT, IdW'(i + 100), LenW'(i + 2));
    end
    add_request(rrqs_pkg::MODE_SUBMIT, 10'd7, 16'd3);
    add_request(rrqs_pkg::MODE_SUBMIT, 10'd8, 16'd0);
    for (int i = 0; i < 5; i++) begin
      add_request(rrqs_pkg::MODE_SCHEDULE, IdW'($urandom_range(0, 1023)),
                  LenW'($urandom_range(0, 65535)));
    end
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          q_pick = '0;
          p_pick = rrqs_pkg::POLICY_RR;
        end
        1: begin
          q_pick = '1;
          p_pick = rrqs_pkg::POLICY_FCFS;
        end
        2: begin
          q_pick = LenW'(1);
          p_pick = rrqs_pkg::POLICY_RR;
        end
        default: begin
          q_pick = ($urandom_range(0, 1) == 0) ? LenW'($urandom_range(1, 12))
                                               : LenW'($urandom_range(0, 65535));
          p_pick = logic'($urandom_range(0, 1));
        end
      endcase
      cfg_write(rrqs_pkg::REG_QUANTUM, DataW'(q_pick));
      cfg_write(rrqs_pkg::REG_POLICY, DataW'(p_pick));
      idle_on = (p != 4) && (p != 7);
      pct = 40 + 10 * (p % 3);
      for (int i = 0; i < PhaseItems; i++) begin
        job_requests.push_back(random_request(pct));
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
